// File: rtl/core/unique_key_fifo_unit_defines.svh
`ifndef UNIQUE_KEY_FIFO_UNIT_DEFINES_SVH
`define UNIQUE_KEY_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define UKF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define UKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ukf_pkg.sv
`default_nettype none

package ukf_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADPOS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PUSH,
        S_POP_RD,
        S_POP_CAP,
        S_RD_WAIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    scan_start;
        logic    scan_step;
        logic    do_push;
        logic    do_pop;
        logic    rd_head;
        logic    rd_pos;
        logic    cap_head;
        logic    cap_result;
        logic    set_status;
        status_t status;
        logic    out_load;
    } ukf_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  full;
        logic  pos_bad;
        logic  scan_done;
        logic  dup;
        logic  out_free;
    } ukf_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ukf_ram.sv
`default_nettype none

module ukf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/ukf_ctrl.sv
`default_nettype none

module ukf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ukf_pkg::ukf_sts_t sts,
    output ukf_pkg::ukf_cmd_t      cmd
);

    import ukf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        in_stall   = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.kind)
                    KIND_PUSH:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    KIND_POP:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            cmd.do_pop = 1'b1;
                            state_next = S_POP_RD;
                        end
                    end
                    KIND_READ:
                    begin
                        if (sts.pos_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                priority if (sts.dup)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DUP;
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                end
                else
                begin
                    cmd.do_push = 1'b1;
                end
                state_next = S_RESP;
            end
            S_POP_RD:
            begin
                // refill the cached head only when something is left
                if (sts.count_zero)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_POP_CAP;
                end
            end
            S_POP_CAP:
            begin
                cmd.cap_head = 1'b1;
                state_next   = S_RESP;
            end
            S_RD_WAIT:
            begin
                cmd.cap_result = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ukf_dp.sv
`default_nettype none

module ukf_dp #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ukf_pkg::ukf_cmd_t                   cmd,
    output ukf_pkg::ukf_sts_t                        sts,
    input  wire logic        [ukf_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [ukf_pkg::KEY_W-1:0]    key,
    input  wire logic signed [ukf_pkg::VAL_W-1:0]    value,
    input  wire logic        [ukf_pkg::POS_W-1:0]    position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [ukf_pkg::STATUS_W-1:0] status,
    output logic signed      [ukf_pkg::KEY_W-1:0]    out_key,
    output logic signed      [ukf_pkg::VAL_W-1:0]    out_value,
    output logic             [ukf_pkg::COUNT_W-1:0]  count,
    output logic signed      [ukf_pkg::KEY_W-1:0]    head_key,
    output logic signed      [ukf_pkg::VAL_W-1:0]    head_value
);

    import ukf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = CW + 1;
    localparam int RW = KEY_W + VAL_W;

    // item and result holding
    kind_t                    kind_reg;
    logic signed [KEY_W-1:0]  key_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic        [POS_W-1:0]  pos_reg;
    status_t                  res_status_reg;
    logic signed [KEY_W-1:0]  res_key_reg;
    logic signed [VAL_W-1:0]  res_val_reg;

    // queue bookkeeping
    logic [PW-1:0] head_ptr_reg;
    logic [PW-1:0] head_ptr_next;
    logic [PW-1:0] tail_ptr_reg;
    logic [PW-1:0] tail_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic signed [KEY_W-1:0] hkey_reg;
    logic signed [VAL_W-1:0] hval_reg;

    // key scan
    logic [CW-1:0] scan_idx_reg;
    logic          cmp_vld_reg;
    logic          match_reg;
    logic          scan_issue;

    // output register
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [KEY_W-1:0]  out_key_reg;
    logic signed [VAL_W-1:0]  out_val_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic signed [KEY_W-1:0]  out_hkey_reg;
    logic signed [VAL_W-1:0]  out_hval_reg;

    // storage access
    logic [POS_W-1:0]        pos_m1;
    logic [CW-1:0]           offset;
    logic [SW-1:0]           slot_sum;
    logic [PW-1:0]           rd_slot;
    logic [RW-1:0]           rdata;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [VAL_W-1:0] rd_val;
    logic                    count_zero;

    assign count_zero = (count_reg == '0);
    assign scan_issue = (scan_idx_reg < count_reg);

    assign pos_m1 = pos_reg - POS_W'(1);

    always_comb
    begin
        priority if (cmd.rd_pos)
        begin
            offset = CW'(pos_m1);
        end
        else if (cmd.rd_head)
        begin
            offset = '0;
        end
        else
        begin
            offset = scan_idx_reg;
        end
    end

    // head plus an offset of at most DEPTH, wrapped once
    assign slot_sum = SW'(head_ptr_reg) + SW'(offset);
    assign rd_slot  = (slot_sum >= SW'(DEPTH)) ? PW'(slot_sum - SW'(DEPTH)) : PW'(slot_sum);

    ukf_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.do_push),
        .waddr (tail_ptr_reg),
        .wdata ({key_reg, value_reg}),
        .raddr (rd_slot),
        .rdata (rdata)
    );

    assign rd_key = rdata[RW-1:VAL_W];
    assign rd_val = rdata[VAL_W-1:0];

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        if (cmd.do_pop)
        begin
            head_ptr_next = (head_ptr_reg == PW'(DEPTH - 1)) ? '0 : head_ptr_reg + PW'(1);
            count_next    = count_reg - CW'(1);
        end
        if (cmd.do_push)
        begin
            tail_ptr_next = (tail_ptr_reg == PW'(DEPTH - 1)) ? '0 : tail_ptr_reg + PW'(1);
            count_next    = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            count_reg    <= count_next;

            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                cmp_vld_reg  <= 1'b0;
                match_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                // issue one slot per cycle, compare the slot read last cycle
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                cmp_vld_reg <= scan_issue;
                if (cmp_vld_reg && (rd_key == key_reg))
                begin
                    match_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg       <= kind_t'(kind);
            key_reg        <= key;
            value_reg      <= value;
            pos_reg        <= position;
            res_status_reg <= ST_OK;
            res_key_reg    <= '0;
            res_val_reg    <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.do_pop)
        begin
            res_key_reg <= hkey_reg;
            res_val_reg <= hval_reg;
        end
        if (cmd.cap_result)
        begin
            res_key_reg <= rd_key;
            res_val_reg <= rd_val;
        end
        if (cmd.cap_head)
        begin
            hkey_reg <= rd_key;
            hval_reg <= rd_val;
        end
        if (cmd.do_push && count_zero)
        begin
            hkey_reg <= key_reg;
            hval_reg <= value_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_val_reg    <= res_val_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_hkey_reg   <= count_zero ? '0 : hkey_reg;
            out_hval_reg   <= count_zero ? '0 : hval_reg;
        end
    end

    always_comb
    begin
        sts.kind       = kind_reg;
        sts.count_zero = count_zero;
        sts.full       = (count_reg == CW'(DEPTH));
        sts.pos_bad    = (pos_reg == '0) || (XW'(pos_reg) > XW'(count_reg));
        sts.scan_done  = !scan_issue && !cmp_vld_reg;
        sts.dup        = match_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_val_reg;
    assign count      = out_count_reg;
    assign head_key   = out_hkey_reg;
    assign head_value = out_hval_reg;

endmodule

`default_nettype wire

// File: rtl/core/unique_key_fifo_unit.sv
// FIFO of up to DEPTH key/value pairs in which every key is unique.
// Input channel (in_valid/in_stall) carries one operation per transaction:
// kind selects push of key/value, pop of the head, or read at a 1-based
// position. Output channel (out_valid/out_stall) returns exactly one result
// per operation: status, the popped or read pair, the entry count and the
// head pair after the operation (zeros when the queue is empty).
// One operation is in flight at a time; in_stall is low only while idle.
// A push first scans every stored key for a duplicate, reading one stored
// entry per cycle through the single read port of the pair store; a pop
// reads the next entry to refill the cached head unless it empties the
// queue; a read at position reads the pair store once. A pop on an empty
// queue, a bad position and an unused kind go straight to the result.
// Operations are serialized, so a new one is accepted only after the
// previous result has been loaded into the output register.
// The result sits in an output register; the next operation is accepted and
// processed while it waits, and only its own result waits on out_stall.
// Reset empties the queue and drops any pending result; stored pairs are not
// cleared since only written entries are ever read.
`default_nettype none

`include "unique_key_fifo_unit_defines.svh"

module unique_key_fifo_unit #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic        [ukf_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [ukf_pkg::KEY_W-1:0]    key,
    input  wire logic signed [ukf_pkg::VAL_W-1:0]    value,
    input  wire logic        [ukf_pkg::POS_W-1:0]    position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [ukf_pkg::STATUS_W-1:0] status,
    output logic signed      [ukf_pkg::KEY_W-1:0]    out_key,
    output logic signed      [ukf_pkg::VAL_W-1:0]    out_value,
    output logic             [ukf_pkg::COUNT_W-1:0]  count,
    output logic signed      [ukf_pkg::KEY_W-1:0]    head_key,
    output logic signed      [ukf_pkg::VAL_W-1:0]    head_value
);

    import ukf_pkg::*;

    ukf_cmd_t cmd;
    ukf_sts_t sts;

    ukf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ukf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .key        (key),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_key    (out_key),
        .out_value  (out_value),
        .count      (count),
        .head_key   (head_key),
        .head_value (head_value)
    );

    `UKF_ASSERT_NOW(a_push_legal, cmd.do_push, !sts.full && !sts.dup, "push write into full queue or with duplicate key")
    `UKF_ASSERT_NOW(a_pop_legal, cmd.do_pop, !sts.count_zero, "pop from empty queue")
    `UKF_ASSERT_NOW(a_out_no_overwrite, cmd.out_load, !(out_valid && out_stall), "result overwritten while stalled")
    `UKF_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction accepted while busy")

endmodule

`default_nettype wire
